// File: hw/rtl/thac_pkg.sv
// Shared widths, register indexes, defaults and control structs for the
// tile horizontal autocorrelation block. No dependencies.
`default_nettype none
package thac_pkg;

	localparam int PIX_W     = 8;
	localparam int SUM_W     = 33;
	localparam int FRAC_W    = 16;
	localparam int RATIO_W   = 17;
	localparam int LAGIDX_W  = 4;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int SIDE_REG_W = 9;
	localparam int LAGS_REG_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAG_COUNT   = 2'd2;

	localparam logic [SIDE_REG_W-1:0] TILE_WIDTH_RST  = 9'd16;
	localparam logic [SIDE_REG_W-1:0] TILE_HEIGHT_RST = 9'd16;
	localparam logic [LAGS_REG_W-1:0] LAG_COUNT_RST   = 5'd16;

	localparam int MAX_LAGS_DEF      = 16;
	localparam int MAX_TILE_SIDE_DEF = 256;

	localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic accum;
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Result of the shared divider
	typedef struct packed {
		logic               done;
		logic               zero;
		logic [RATIO_W-1:0] ratio;
	} div_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/thac_cell.sv
// One lag cell of the autocorrelation chain: one pixel tap and one lag sum.
// Depends on thac_pkg.
`default_nettype none
module thac_cell #(
	parameter int LAG   = 0,
	parameter int POS_W = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  thac_pkg::cell_ctrl_t            ctrl,
	input  wire  [POS_W-1:0]                col,
	input  wire  [thac_pkg::PIX_W-1:0]      pixel,
	input  wire  [thac_pkg::PIX_W-1:0]      tap_in,
	output logic [thac_pkg::PIX_W-1:0]      tap_out,
	input  wire  [thac_pkg::SUM_W-1:0]      sum_in,
	output logic [thac_pkg::SUM_W-1:0]      sum_out
);

	logic [thac_pkg::PIX_W-1:0]   tap_q;
	logic [thac_pkg::SUM_W-1:0]   sum_q;
	logic [2*thac_pkg::PIX_W-1:0] prod;
	logic                         pair_ok;

	assign prod    = tap_in * pixel;
	// only pairs that lie inside the current row
	assign pair_ok = (32'(col) >= 32'(LAG));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			sum_q <= '0;
		end else begin
			if (ctrl.accum) begin
				tap_q <= tap_in;
				if (pair_ok) begin
					sum_q <= sum_q + thac_pkg::SUM_W'(prod);
				end
			end else if (ctrl.clear) begin
				sum_q <= '0;
			end else if (ctrl.shift) begin
				sum_q <= sum_in;
			end
		end
	end

	assign tap_out = tap_q;
	assign sum_out = sum_q;

endmodule
`default_nettype wire

// File: hw/rtl/thac_div.sv
// Restoring divider: lag sum over lag-0 sum in Q0.16, one quotient bit per
// cycle, with saturation at 1.0 and a zero-divisor flag. Depends on thac_pkg.
`default_nettype none
module thac_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          take,
	input  wire  [thac_pkg::SUM_W-1:0]   dividend,
	input  wire  [thac_pkg::SUM_W-1:0]   divisor,
	output thac_pkg::div_res_t           res
);

	localparam int STEP_W = $clog2(thac_pkg::FRAC_W + 1);

	logic                          busy_q;
	logic                          done_q;
	logic                          zero_q;
	logic                          sat_q;
	logic [STEP_W-1:0]             step_q;
	logic [thac_pkg::SUM_W-1:0]    rem_q;
	logic [thac_pkg::SUM_W-1:0]    dvs_q;
	logic [thac_pkg::FRAC_W-1:0]   quo_q;
	logic [thac_pkg::SUM_W:0]      rem2;
	logic                          fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = (rem2 >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			sat_q  <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			dvs_q  <= divisor;
			rem_q  <= dividend;
			quo_q  <= '0;
			zero_q <= 1'b0;
			sat_q  <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			if (divisor == '0) begin
				zero_q <= 1'b1;
				done_q <= 1'b1;
			end else if (dividend >= divisor) begin
				// quotient at or above 1.0: saturate
				sat_q  <= 1'b1;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(thac_pkg::FRAC_W);
			end
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= thac_pkg::SUM_W'(rem2 - {1'b0, dvs_q});
			end else begin
				rem_q <= thac_pkg::SUM_W'(rem2);
			end
			quo_q  <= {quo_q[thac_pkg::FRAC_W-2:0], fits};
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (take) begin
			done_q <= 1'b0;
		end
	end

	assign res.done  = done_q;
	assign res.zero  = zero_q;
	assign res.ratio = sat_q ? thac_pkg::RATIO_ONE : {1'b0, quo_q};

endmodule
`default_nettype wire

// File: hw/rtl/tile_horizontal_autocorrelation_top.sv
// Tile horizontal autocorrelation, top level: lag cell chain, divider, control.
// Readout: after the tile's last pixel, lag 0 goes via ST_START and the divider
// into the output register; other lags come direct (ratio 1.0, zero energy) or
// after 16 divider steps; all wait while out_ready is low. Throughput: one pixel
// per cycle in a tile; pixels are held off until the tile's last lag item is loaded.
// Reset: arst_n clears sums, positions and outputs, loads 16 x 16 tile, 16 lags.
`default_nettype none
module tile_horizontal_autocorrelation_top #(
	parameter int MAX_LAGS      = thac_pkg::MAX_LAGS_DEF,
	parameter int MAX_TILE_SIDE = thac_pkg::MAX_TILE_SIDE_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration write port
	input  wire                                cfg_we,
	input  wire  [thac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [thac_pkg::CFG_W-1:0]         cfg_data,
	// pixel items
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [thac_pkg::PIX_W-1:0]         pixel,
	// result items
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [thac_pkg::LAGIDX_W-1:0]      lag_index,
	output logic [thac_pkg::RATIO_W-1:0]       ratio,
	output logic                               zero_energy,
	output logic                               last
);

	localparam int POS_W     = $clog2(MAX_TILE_SIDE);
	localparam int SIDE_CLOG = $clog2(MAX_TILE_SIDE + 1);
	localparam int CMP_W     = (thac_pkg::SIDE_REG_W > SIDE_CLOG) ?
	                           thac_pkg::SIDE_REG_W : SIDE_CLOG;
	localparam int LAG_CNT_W = $clog2(MAX_LAGS + 1);

	localparam logic [1:0] ST_ACC   = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	// configuration registers keep the written bits (lag count only its low five); clamping is applied on use
	logic [thac_pkg::SIDE_REG_W-1:0] tile_width_q;
	logic [thac_pkg::SIDE_REG_W-1:0] tile_height_q;
	logic [thac_pkg::LAGS_REG_W-1:0] lag_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= thac_pkg::TILE_WIDTH_RST;
			tile_height_q <= thac_pkg::TILE_HEIGHT_RST;
			lag_count_q   <= thac_pkg::LAG_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thac_pkg::REG_TILE_WIDTH:  tile_width_q  <= cfg_data;
				thac_pkg::REG_TILE_HEIGHT: tile_height_q <= cfg_data;
				thac_pkg::REG_LAG_COUNT:
					lag_count_q <= cfg_data[thac_pkg::LAGS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp zero to one and large values to the build limits
	logic [CMP_W-1:0]     width_raw, height_raw, width_eff, height_eff;
	logic [LAG_CNT_W-1:0] lags_eff;

	assign width_raw  = CMP_W'(tile_width_q);
	assign height_raw = CMP_W'(tile_height_q);

	always_comb begin
		if (width_raw == '0) begin
			width_eff = CMP_W'(1);
		end else if (width_raw > CMP_W'(MAX_TILE_SIDE)) begin
			width_eff = CMP_W'(MAX_TILE_SIDE);
		end else begin
			width_eff = width_raw;
		end
		if (height_raw == '0) begin
			height_eff = CMP_W'(1);
		end else if (height_raw > CMP_W'(MAX_TILE_SIDE)) begin
			height_eff = CMP_W'(MAX_TILE_SIDE);
		end else begin
			height_eff = height_raw;
		end
		if (lag_count_q == '0) begin
			lags_eff = LAG_CNT_W'(1);
		end else if (32'(lag_count_q) > 32'(MAX_LAGS)) begin
			lags_eff = LAG_CNT_W'(MAX_LAGS);
		end else begin
			lags_eff = LAG_CNT_W'(lag_count_q);
		end
	end

	// control state
	logic [1:0]                  state_q;
	logic [POS_W-1:0]            col_q;
	logic [POS_W-1:0]            row_q;
	logic [LAG_CNT_W-1:0]        lag_cnt_q;
	logic [thac_pkg::SUM_W-1:0]  divisor_q;

	logic                        in_fire;
	logic                        row_end;
	logic                        tile_end;
	logic                        out_free;
	logic                        last_lag;
	logic                        div_start;
	logic                        div_take;
	logic [thac_pkg::SUM_W-1:0]  div_divisor;
	thac_pkg::cell_ctrl_t        ctrl;
	thac_pkg::div_res_t          dres;

	// chain links: taps move right with each pixel, sums move left on readout
	logic [thac_pkg::PIX_W-1:0]  tap_link [MAX_LAGS];
	logic [thac_pkg::SUM_W-1:0]  sum_link [MAX_LAGS+1];

	assign in_ready = (state_q == ST_ACC);
	assign in_fire  = in_valid && in_ready;
	assign row_end  = ((CMP_W'(col_q) + CMP_W'(1)) >= width_eff);
	assign tile_end = row_end && ((CMP_W'(row_q) + CMP_W'(1)) >= height_eff);
	assign out_free = !out_valid || out_ready;
	assign last_lag = ((lag_cnt_q + LAG_CNT_W'(1)) == lags_eff);

	always_comb begin
		ctrl        = '0;
		div_start   = 1'b0;
		div_take    = 1'b0;
		div_divisor = divisor_q;
		ctrl.accum  = in_fire;
		unique case (state_q)
			ST_ACC: ;
			ST_START: begin
				// lag 0 sits at the head of the chain and is its own divisor
				div_start   = 1'b1;
				div_divisor = sum_link[0];
				ctrl.shift  = 1'b1;
			end
			ST_DIV: begin
				if (dres.done && out_free) begin
					div_take = 1'b1;
					if (last_lag) begin
						ctrl.clear = 1'b1;
					end else begin
						div_start  = 1'b1;
						ctrl.shift = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACC;
			col_q     <= '0;
			row_q     <= '0;
			lag_cnt_q <= '0;
			divisor_q <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (in_fire) begin
						if (!row_end) begin
							col_q <= col_q + 1'b1;
						end else begin
							col_q <= '0;
							if (tile_end) begin
								row_q   <= '0;
								state_q <= ST_START;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end
					end
				end
				ST_START: begin
					divisor_q <= sum_link[0];
					lag_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_take) begin
						if (last_lag) begin
							lag_cnt_q <= '0;
							state_q   <= ST_ACC;
						end else begin
							lag_cnt_q <= lag_cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// output register: hold a result until taken, accept pixels meanwhile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			lag_index   <= '0;
			ratio       <= '0;
			zero_energy <= 1'b0;
			last        <= 1'b0;
		end else if (div_take) begin
			out_valid   <= 1'b1;
			lag_index   <= thac_pkg::LAGIDX_W'(lag_cnt_q);
			ratio       <= dres.zero ? '0 : dres.ratio;
			zero_energy <= dres.zero;
			last        <= last_lag;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// lag cell chain
	assign sum_link[MAX_LAGS] = '0;
	assign tap_link[0]        = pixel;

	for (genvar k = 0; k < MAX_LAGS; k++) begin : g_cell
		if (k < MAX_LAGS - 1) begin : g_mid
			thac_cell #(
				.LAG   (k),
				.POS_W (POS_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.col     (col_q),
				.pixel   (pixel),
				.tap_in  (tap_link[k]),
				.tap_out (tap_link[k+1]),
				.sum_in  (sum_link[k+1]),
				.sum_out (sum_link[k])
			);
		end else begin : g_end
			thac_cell #(
				.LAG   (k),
				.POS_W (POS_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.col     (col_q),
				.pixel   (pixel),
				.tap_in  (tap_link[k]),
				.tap_out (),
				.sum_in  (sum_link[k+1]),
				.sum_out (sum_link[k])
			);
		end
	end

	thac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.take     (div_take),
		.dividend (sum_link[0]),
		.divisor  (div_divisor),
		.res      (dres)
	);

endmodule
`default_nettype wire

// File: hw/rtl/thac_checker.sv
// Port-level checker for the tile horizontal autocorrelation top level, bound
// to it below. Depends on thac_pkg.
`default_nettype none
module thac_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire [thac_pkg::PIX_W-1:0]          pixel,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire [thac_pkg::LAGIDX_W-1:0]       lag_index,
	input wire [thac_pkg::RATIO_W-1:0]        ratio,
	input wire                                zero_energy,
	input wire                                last
);

	// a waiting pixel holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pixel))
		else $error("pixel changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ratio) && $stable(lag_index)
		&& $stable(last) && $stable(zero_energy))
		else $error("result changed while stalled");

	a_zero_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_energy |-> ratio == '0)
		else $error("zero energy with nonzero ratio");

	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ratio <= thac_pkg::RATIO_ONE)
		else $error("ratio above 1.0");

	a_lag0_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lag_index == '0 && !zero_energy |-> ratio == thac_pkg::RATIO_ONE)
		else $error("lag 0 ratio is not 1.0");

endmodule

bind tile_horizontal_autocorrelation_top thac_checker u_thac_checker (.*);
`default_nettype wire
